/* sv/sysres_pkg.sv */
// Package for the systematic resampler: sizes, opcodes and derived widths.
// Used by systematic_resampler.sv and the bench files; depends on nothing else.
package sysres_pkg;
   localparam int MAX_PARTICLES = 64;
   localparam int WEIGHT_BITS   = 32;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int SUM_W         = WEIGHT_BITS + IDX_W;
   localparam int ID_W          = 32;
   localparam int FRAC_W        = 16;
   // Shared multiplier: a sum-wide operand times a fraction-wide operand.
   localparam int MUL_W         = SUM_W + FRAC_W;
   // cum * n, with n at most MAX_PARTICLES.
   localparam int RHS_W         = SUM_W + CNT_W;
   // Pointer (IDX_W + FRAC_W bits) times total (SUM_W bits).
   localparam int LHS_W         = IDX_W + FRAC_W + SUM_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_PARTICLES);
endpackage

/* sv/systematic_resampler.sv */
// Systematic resampler top level: particle store, walk sequencer, shared multiplier.
// Depends on sysres_pkg for widths and opcodes.
//
//  channel  ports               handshake
//  -------  ------------------  ---------------------------------------
//  request  start, busy, req_*  item taken when start is high, busy low
//  result   rsp_valid, rsp_*    one-cycle strobe, always taken
//
// A load item never raises busy. A run item over N loaded particles keeps busy high
// through the init, read and multiply states, one compare per slot, and for each of
// the A <= N - 1 walk advances a store read, a pass through the shared multiplier
// and a compare. The last result is on the ports in the first cycle after busy falls.
// Reset is synchronous and empties the store. The receiver cannot stall results.
module systematic_resampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [31:0]                   req_weight,
   input  logic                          req_weight_invalid,
   input  logic [31:0]                   req_particle_ident,
   input  logic [15:0]                   req_start_offset,
   input  logic [31:0]                   req_selected_ident,
   input  logic [31:0]                   req_next_id_base,
   output logic                          rsp_valid,
   output logic [sysres_pkg::IDX_W-1:0]  rsp_slot_index,
   output logic [sysres_pkg::IDX_W-1:0]  rsp_source_index,
   output logic [31:0]                   rsp_new_ident,
   output logic                          rsp_kept_selected,
   output logic [31:0]                   rsp_next_id_after,
   output logic                          rsp_last
);
   localparam int IDX_W  = sysres_pkg::IDX_W;
   localparam int CNT_W  = sysres_pkg::CNT_W;
   localparam int SUM_W  = sysres_pkg::SUM_W;
   localparam int ID_W   = sysres_pkg::ID_W;
   localparam int FRAC_W = sysres_pkg::FRAC_W;
   localparam int MUL_W  = sysres_pkg::MUL_W;
   localparam int RHS_W  = sysres_pkg::RHS_W;
   localparam int LHS_W  = sysres_pkg::LHS_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INIT = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;

   logic [SUM_W-1:0] sum_mem [sysres_pkg::MAX_PARTICLES];
   logic [ID_W-1:0]  id_mem  [sysres_pkg::MAX_PARTICLES];

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              invalid_ff, invalid_in;
   logic [SUM_W-1:0]  last_sum_ff, last_sum_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              uniform_ff, uniform_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [FRAC_W-1:0] offset_ff, offset_in;
   logic [ID_W-1:0]   sel_ff, sel_in;
   logic [ID_W-1:0]   next_id_ff, next_id_in;
   logic              kept_ff, kept_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;
   logic [RHS_W-1:0]  rhs_ff, rhs_in;
   logic [SUM_W-1:0]  cum_ff;
   logic [ID_W-1:0]   ident_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [IDX_W-1:0]  rsp_src_ff, rsp_src_in;
   logic [ID_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic              rsp_kept_ff, rsp_kept_in;
   logic [ID_W-1:0]   rsp_next_ff, rsp_next_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              load_we;
   logic [SUM_W-1:0]  new_sum;
   logic [SUM_W-1:0]  mul_a;
   logic [FRAC_W-1:0] mul_b;
   logic [MUL_W-1:0]  mul_p;
   logic [SUM_W-1:0]  cum_eff;
   logic              can_advance;
   logic              ptr_past;
   logic              keep;
   logic              last_slot;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign load_we = accept && (req_opcode == sysres_pkg::OP_LOAD)
                    && (count_ff != sysres_pkg::CAP);
   assign new_sum = last_sum_ff + SUM_W'(req_weight);

   assign cum_eff = uniform_ff ? SUM_W'(idx_ff) + SUM_W'(1) : cum_ff;

   // One multiplier serves both the start product u*total and each cum*n.
   always_comb begin
      if (state_ff == S_INIT) begin
         mul_a = total_ff;
         mul_b = offset_ff;
      end else begin
         mul_a = cum_eff;
         mul_b = FRAC_W'(n_ff);
      end
   end
   assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

   // The pointer has passed particle idx when ptr*total > cum*n*2^16.
   assign can_advance = (CNT_W'(idx_ff) + CNT_W'(1)) < n_ff;
   assign ptr_past    = lhs_ff > {rhs_ff[LHS_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
   assign keep        = (ident_ff == sel_ff) && !kept_ff;
   assign last_slot   = (CNT_W'(slot_ff) + CNT_W'(1)) == n_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      invalid_in   = invalid_ff;
      last_sum_in  = last_sum_ff;
      n_in         = n_ff;
      uniform_in   = uniform_ff;
      total_in     = total_ff;
      offset_in    = offset_ff;
      sel_in       = sel_ff;
      next_id_in   = next_id_ff;
      kept_in      = kept_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      rsp_valid_in = 1'b0;
      rsp_slot_in  = rsp_slot_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (load_we) begin
               count_in    = count_ff + CNT_W'(1);
               invalid_in  = invalid_ff | req_weight_invalid;
               last_sum_in = new_sum;
            end
            if (accept && (req_opcode == sysres_pkg::OP_RUN)
                && (count_ff != CNT_W'(0))) begin
               n_in       = count_ff;
               uniform_in = invalid_ff || (last_sum_ff == SUM_W'(0));
               total_in   = (invalid_ff || (last_sum_ff == SUM_W'(0)))
                            ? SUM_W'(count_ff) : last_sum_ff;
               offset_in  = req_start_offset;
               sel_in     = req_selected_ident;
               next_id_in = req_next_id_base;
               state_in   = S_INIT;
            end
         end
         S_INIT: begin
            lhs_in   = LHS_W'(mul_p);
            idx_in   = '0;
            slot_in  = '0;
            kept_in  = 1'b0;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            rhs_in   = RHS_W'(mul_p);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (can_advance && ptr_past) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ff;
               rsp_src_in   = idx_ff;
               rsp_kept_in  = keep;
               rsp_last_in  = last_slot;
               if (keep) begin
                  kept_in      = 1'b1;
                  rsp_ident_in = ident_ff;
                  rsp_next_in  = next_id_ff;
               end else begin
                  rsp_ident_in = next_id_ff;
                  rsp_next_in  = next_id_ff + ID_W'(1);
                  next_id_in   = next_id_ff + ID_W'(1);
               end
               if (last_slot) begin
                  count_in    = '0;
                  invalid_in  = 1'b0;
                  last_sum_in = '0;
                  state_in    = S_IDLE;
               end else begin
                  slot_in = slot_ff + IDX_W'(1);
                  lhs_in  = lhs_ff + LHS_W'({total_ff, {FRAC_W{1'b0}}});
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         invalid_ff   <= 1'b0;
         last_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         invalid_ff   <= invalid_in;
         last_sum_ff  <= last_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      uniform_ff   <= uniform_in;
      total_ff     <= total_in;
      offset_ff    <= offset_in;
      sel_ff       <= sel_in;
      next_id_ff   <= next_id_in;
      kept_ff      <= kept_in;
      idx_ff       <= idx_in;
      slot_ff      <= slot_in;
      lhs_ff       <= lhs_in;
      rhs_ff       <= rhs_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Particle store: one write port for loads, one registered read at the walk index.
   always_ff @(posedge clock) begin
      if (load_we) begin
         sum_mem[count_ff[IDX_W-1:0]] <= new_sum;
         id_mem[count_ff[IDX_W-1:0]]  <= req_particle_ident;
      end
      cum_ff   <= sum_mem[idx_ff];
      ident_ff <= id_mem[idx_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_source_index  = rsp_src_ff;
   assign rsp_new_ident     = rsp_ident_ff;
   assign rsp_kept_selected = rsp_kept_ff;
   assign rsp_next_id_after = rsp_next_ff;
   assign rsp_last          = rsp_last_ff;
endmodule

/* bench/resampled_slot_check.sv */
// Slot result checker for the systematic resampler: tracks the particle store,
// predicts every slot a run emits and compares it with the result strobe.
// Depends on sysres_pkg for widths, opcodes and the store size.
`timescale 1ns / 100ps

module resampled_slot_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_opcode,
   input  logic [31:0]                     req_weight,
   input  logic                            req_weight_invalid,
   input  logic [31:0]                     req_particle_ident,
   input  logic [15:0]                     req_start_offset,
   input  logic [31:0]                     req_selected_ident,
   input  logic [31:0]                     req_next_id_base,
   input  logic                            rsp_valid,
   input  logic [sysres_pkg::IDX_W-1:0]    rsp_slot_index,
   input  logic [sysres_pkg::IDX_W-1:0]    rsp_source_index,
   input  logic [31:0]                     rsp_new_ident,
   input  logic                            rsp_kept_selected,
   input  logic [31:0]                     rsp_next_id_after,
   input  logic                            rsp_last,
   output int                              failures,
   output int                              pending,
   output int                              slots_seen
);

   typedef struct packed {
      logic [sysres_pkg::IDX_W-1:0] slot;
      logic [sysres_pkg::IDX_W-1:0] source;
      logic [31:0]                  ident;
      logic                         kept;
      logic [31:0]                  next_after;
      logic                         last;
   } slot_result_type;

   slot_result_type               expected_slots[$];
   logic [sysres_pkg::SUM_W-1:0]  cum_weight [sysres_pkg::MAX_PARTICLES];
   logic [31:0]                   stored_ident [sysres_pkg::MAX_PARTICLES];
   int                            loaded;
   logic                          any_invalid;

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: slot %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         failures++;
      end
   endtask

   // A load on a full store is dropped whole, its invalid flag included.
   task automatic append_particle(input logic [31:0] w, input logic inv,
                                  input logic [31:0] id);
      if (loaded >= sysres_pkg::MAX_PARTICLES)
         return;
      cum_weight[loaded] = (loaded == 0) ? sysres_pkg::SUM_W'(w)
                           : cum_weight[loaded - 1] + sysres_pkg::SUM_W'(w);
      stored_ident[loaded] = id;
      any_invalid = any_invalid | inv;
      loaded++;
   endtask

   // Slot i takes the first particle whose cumulative weight is not below
   // (i + u) / N of the total; compared as exact cross products.
   task automatic resample(input logic [15:0] off, input logic [31:0] sel,
                           input logic [31:0] base);
      int              n;
      int              idx;
      logic [63:0]     total;
      logic [63:0]     scale;
      logic [63:0]     ptr;
      logic [63:0]     cum;
      logic [127:0]    lhs;
      logic [127:0]    rhs;
      logic            uniform;
      logic            kept;
      logic            done;
      logic [31:0]     next_id;
      logic [31:0]     ident;
      slot_result_type r;
      n = loaded;
      if (n == 0)
         return;
      total = 64'(cum_weight[n - 1]);
      uniform = any_invalid || (total == 64'd0);
      if (uniform)
         total = 64'(n);
      scale = 64'(n) << 16;
      idx = 0;
      kept = 1'b0;
      next_id = base;
      for (int i = 0; i < n; i++) begin
         ptr = (64'(i) << 16) + 64'(off);
         done = 1'b0;
         while (!done && idx + 1 < n) begin
            cum = uniform ? 64'(idx + 1) : 64'(cum_weight[idx]);
            lhs = {64'd0, ptr} * {64'd0, total};
            rhs = {64'd0, cum} * {64'd0, scale};
            if (lhs > rhs)
               idx++;
            else
               done = 1'b1;
         end
         ident = stored_ident[idx];
         r.kept = (ident == sel) && !kept;
         if (r.kept) begin
            kept = 1'b1;
         end else begin
            ident = next_id;
            next_id = next_id + 32'd1;
         end
         r.slot = sysres_pkg::IDX_W'(i);
         r.source = sysres_pkg::IDX_W'(idx);
         r.ident = ident;
         r.next_after = next_id;
         r.last = (i == n - 1);
         expected_slots = {expected_slots, r};
      end
      loaded = 0;
      any_invalid = 1'b0;
   endtask

   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         expected_slots.delete();
         loaded = 0;
         any_invalid = 1'b0;
         failures = 0;
         slots_seen = 0;
      end else begin
         // Results are retired before a new item is taken in the same cycle.
         if (rsp_valid) begin
            slots_seen++;
            if (expected_slots.size() == 0) begin
               $display("%0t: unexpected slot result, slot %0d source %0d ident 0x%0h",
                        $time, rsp_slot_index, rsp_source_index, rsp_new_ident);
               failures++;
            end else begin
               want = expected_slots.pop_front();
               check_field("slot_index", 32'(want.slot), 32'(rsp_slot_index));
               check_field("source_index", 32'(want.source), 32'(rsp_source_index));
               check_field("new_ident", want.ident, rsp_new_ident);
               check_field("kept_selected", 32'(want.kept), 32'(rsp_kept_selected));
               check_field("next_id_after", want.next_after, rsp_next_id_after);
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (start && !busy) begin
            if (req_opcode == sysres_pkg::OP_LOAD)
               append_particle(req_weight, req_weight_invalid, req_particle_ident);
            else
               resample(req_start_offset, req_selected_ident, req_next_id_base);
         end
      end
      pending = expected_slots.size();
   end

endmodule

/* bench/systematic_resampler_tb.sv */
// Testbench top for the systematic resampler: clock, reset, particle sets and
// runs as stimulus, a watchdog and the verdict. Needs sysres_pkg, the block and
// resampled_slot_check, which does the prediction and comparison.
`timescale 1ns / 100ps

module systematic_resampler_tb;

   localparam int ITEM_TARGET  = 320;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 300;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_opcode;
   logic [31:0]                   req_weight;
   logic                          req_weight_invalid;
   logic [31:0]                   req_particle_ident;
   logic [15:0]                   req_start_offset;
   logic [31:0]                   req_selected_ident;
   logic [31:0]                   req_next_id_base;
   logic                          rsp_valid;
   logic [sysres_pkg::IDX_W-1:0]  rsp_slot_index;
   logic [sysres_pkg::IDX_W-1:0]  rsp_source_index;
   logic [31:0]                   rsp_new_ident;
   logic                          rsp_kept_selected;
   logic [31:0]                   rsp_next_id_after;
   logic                          rsp_last;

   int          slot_failures;
   int          slots_pending;
   int          slots_compared;
   int          items_sent = 0;
   int          loads_sent = 0;
   int          loads_dropped = 0;
   int          runs_sent = 0;
   int          set_fill = 0;
   int          stall_cycles = 0;
   bit          burst = 1'b0;
   logic [31:0] set_idents[$];

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   systematic_resampler DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_weight         (req_weight),
      .req_weight_invalid (req_weight_invalid),
      .req_particle_ident (req_particle_ident),
      .req_start_offset   (req_start_offset),
      .req_selected_ident (req_selected_ident),
      .req_next_id_base   (req_next_id_base),
      .rsp_valid          (rsp_valid),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_source_index   (rsp_source_index),
      .rsp_new_ident      (rsp_new_ident),
      .rsp_kept_selected  (rsp_kept_selected),
      .rsp_next_id_after  (rsp_next_id_after),
      .rsp_last           (rsp_last)
   );

   resampled_slot_check slot_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_weight         (req_weight),
      .req_weight_invalid (req_weight_invalid),
      .req_particle_ident (req_particle_ident),
      .req_start_offset   (req_start_offset),
      .req_selected_ident (req_selected_ident),
      .req_next_id_base   (req_next_id_base),
      .rsp_valid          (rsp_valid),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_source_index   (rsp_source_index),
      .rsp_new_ident      (rsp_new_ident),
      .rsp_kept_selected  (rsp_kept_selected),
      .rsp_next_id_after  (rsp_next_id_after),
      .rsp_last           (rsp_last),
      .failures           (slot_failures),
      .pending            (slots_pending),
      .slots_seen         (slots_compared)
   );

   // Ends the run when neither an item nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no item or result for %0d cycles", $time, STALL_LIMIT);
         $display("[systematic_resampler] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Mostly back to back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 65)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input logic op, input logic [31:0] w, input logic inv,
                            input logic [31:0] id, input logic [15:0] off,
                            input logic [31:0] sel, input logic [31:0] base);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_weight = w;
      req_weight_invalid = inv;
      req_particle_ident = id;
      req_start_offset = off;
      req_selected_ident = sel;
      req_next_id_base = base;
      do @(posedge clock); while (busy);
   endtask

   task automatic load_particle(input logic [31:0] w, input logic inv,
                                input logic [31:0] id);
      if (set_fill < sysres_pkg::MAX_PARTICLES) begin
         items_sent++;
         loads_sent++;
         set_idents = {set_idents, id};
      end else begin
         loads_dropped++;
      end
      set_fill++;
      send_item(sysres_pkg::OP_LOAD, w, inv, id, 16'($urandom), $urandom, $urandom);
   endtask

   task automatic run_resample(input logic [15:0] off, input logic [31:0] sel,
                               input logic [31:0] base);
      items_sent++;
      runs_sent++;
      send_item(sysres_pkg::OP_RUN, $urandom, 1'($urandom), $urandom, off, sel, base);
      set_fill = 0;
      set_idents.delete();
   endtask

   task automatic wait_for_slots();
      @(negedge clock);
      start = 1'b0;
      while (slots_pending != 0) @(negedge clock);
   endtask

   // One set of loads with a weight pattern and a pool of repeated ids, then a run.
   task automatic random_set(input int n_loads);
      int          mode;
      int          k;
      bit          invalid_set;
      logic [31:0] w;
      logic [31:0] id;
      logic [31:0] pool [4];
      logic [15:0] off;
      logic [31:0] sel;
      logic [31:0] base;
      int          roll;
      mode = $urandom_range(0, 4);
      burst = ($urandom_range(0, 9) < 3);
      invalid_set = ($urandom_range(0, 7) == 0);
      for (k = 0; k < 4; k++)
         pool[k] = $urandom;
      for (k = 0; k < n_loads; k++) begin
         case (mode)
            0: w = $urandom;
            1: w = $urandom_range(0, 15);
            2: w = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
            3: w = 32'd0;
            default: w = $urandom | 32'h8000_0000;
         endcase
         id = ($urandom_range(0, 1) == 1) ? pool[$urandom_range(0, 3)] : $urandom;
         load_particle(w, invalid_set && ($urandom_range(0, n_loads) == 0), id);
      end
      roll = $urandom_range(0, 99);
      off = (roll < 10) ? 16'h0000 : (roll < 20) ? 16'hFFFF : 16'($urandom);
      if (set_idents.size() > 0 && $urandom_range(0, 9) < 6)
         sel = set_idents[$urandom_range(0, set_idents.size() - 1)];
      else
         sel = $urandom;
      base = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 8) : $urandom;
      run_resample(off, sel, base);
   endtask

   initial begin
      int roll;
      int n_loads;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = sysres_pkg::OP_LOAD;
      req_weight = '0;
      req_weight_invalid = 1'b0;
      req_particle_ident = '0;
      req_start_offset = '0;
      req_selected_ident = '0;
      req_next_id_base = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A run with nothing loaded emits nothing.
      run_resample(16'h1234, 32'h0000_0000, 32'h0000_0010);
      // All weights zero: uniform fallback, duplicate selected id, id wrap.
      load_particle(32'h0000_0000, 1'b0, 32'hA5A5_0001);
      load_particle(32'h0000_0000, 1'b0, 32'hA5A5_0001);
      run_resample(16'h0000, 32'hA5A5_0001, 32'hFFFF_FFFF);
      // One invalid weight forces the fallback despite a nonzero total.
      load_particle(32'h0000_0000, 1'b0, 32'h0000_0011);
      load_particle(32'hFFFF_FFFF, 1'b0, 32'h0000_0022);
      load_particle(32'h0000_0001, 1'b1, 32'h0000_0033);
      load_particle(32'h0001_0000, 1'b0, 32'h0000_0044);
      run_resample(16'hFFFF, 32'h0000_0022, 32'h0000_0100);
      // Zero weights with pointers landing exactly on cumulative values.
      load_particle(32'h0000_0000, 1'b0, 32'hFFFF_FFFF);
      load_particle(32'h0001_0000, 1'b0, 32'h8000_0000);
      load_particle(32'h0000_0000, 1'b0, 32'h7FFF_FFFF);
      load_particle(32'h0001_0000, 1'b0, 32'h0000_0000);
      run_resample(16'h0000, 32'hFFFF_FFFF, 32'h5555_5555);
      // Sums past 32 bits and a zero-weight tail that the walk must not pass.
      load_particle(32'hFFFF_FFFF, 1'b0, 32'h1234_5678);
      load_particle(32'hFFFF_FFFF, 1'b0, 32'h9ABC_DEF0);
      load_particle(32'h0000_0000, 1'b0, 32'h0F0F_0F0F);
      run_resample(16'h8000, 32'h0F0F_0F0F, 32'hAAAA_AAAA);
      wait_for_slots();

      // A full store first, with loads beyond the last entry.
      random_set(sysres_pkg::MAX_PARTICLES + 2);
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            run_resample(16'($urandom), $urandom, $urandom);
         roll = $urandom_range(0, 99);
         if (roll < 75)
            n_loads = $urandom_range(1, 6);
         else if (roll < 93)
            n_loads = $urandom_range(7, 20);
         else if (roll < 98)
            n_loads = $urandom_range(21, sysres_pkg::MAX_PARTICLES - 1);
         else
            n_loads = $urandom_range(sysres_pkg::MAX_PARTICLES,
                                     sysres_pkg::MAX_PARTICLES + 2);
         random_set(n_loads);
         if ($urandom_range(0, 4) == 0)
            wait_for_slots();
      end

      wait_for_slots();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d loads (%0d dropped on a full store) and %0d runs;",
               loads_sent, loads_dropped, runs_sent);
      $display("%0d slot results were compared field by field.", slots_compared);
      if (slot_failures == 0)
         $display("[systematic_resampler] OK");
      else
         $display("[systematic_resampler] ERROR");
      $finish;
   end

endmodule
